### rtl/rme_pkg.sv
// ----------------------------------------------------------------------------
// rme_pkg
// Shared transfer types and codes for the randomized multiset engine.
// ----------------------------------------------------------------------------
package rme_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_FULL  = 2'd1;
  localparam logic [1:0] ERR_EMPTY = 2'd2;

  localparam int RND_W   = 16;
  localparam int TOTAL_W = 9;

  typedef struct packed {
    logic [1:0]        opcode;
    logic signed [31:0] item_value;
    logic [RND_W-1:0]  random_word;
  } cmd_t;

  typedef struct packed {
    logic               op_flag;
    logic signed [31:0] sampled_value;
    logic [1:0]         error_code;
    logic [TOTAL_W-1:0] element_total;
  } result_t;

endpackage

### rtl/rme_store.sv
// ----------------------------------------------------------------------------
// rme_store
// Element memory: value and copy rank per slot, one write and one
// registered read port.
// ----------------------------------------------------------------------------
module rme_store #(
  parameter int CAPACITY = 256,
  parameter int AW = $clog2(CAPACITY),
  parameter int CW = $clog2(CAPACITY + 1)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [31:0]       wvalue,
  input  logic [CW-1:0]     wrank,
  input  logic [AW-1:0]     raddr,
  output logic [31:0]       rvalue,
  output logic [CW-1:0]     rrank
);
  logic [31:0]   value_mem [CAPACITY];
  logic [CW-1:0] rank_mem  [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      value_mem[waddr] <= wvalue;
      rank_mem[waddr]  <= wrank;
    end
    rvalue <= value_mem[raddr];
    rrank  <= rank_mem[raddr];
  end
endmodule

### rtl/rme_mod.sv
// ----------------------------------------------------------------------------
// rme_mod
// Restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module rme_mod #(
  parameter int CW = 9
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    go,
  input  logic [rme_pkg::RND_W-1:0] dividend,
  input  logic [CW-1:0]           divisor,
  output logic                    fin,
  output logic [CW-1:0]           remainder
);
  import rme_pkg::*;
  localparam int BW = $clog2(RND_W);

  logic             run;
  logic [BW-1:0]    bit_cnt;
  logic [RND_W-1:0] shreg;
  logic [CW:0]      trial;

  assign trial = {remainder, shreg[RND_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      fin <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (go) begin
        run       <= 1'b1;
        shreg     <= dividend;
        remainder <= '0;
        bit_cnt   <= '0;
      end else if (run) begin
        if (trial >= {1'b0, divisor}) begin
          remainder <= CW'(trial - {1'b0, divisor});
        end else begin
          remainder <= trial[CW-1:0];
        end
        shreg   <= shreg << 1;
        bit_cnt <= bit_cnt + 1'b1;
        if (bit_cnt == BW'(RND_W - 1)) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end
    end
  end
endmodule

### rtl/randomized_multiset_engine.sv
// ----------------------------------------------------------------------------
// randomized_multiset_engine
// Multiset of 32-bit values in a dense slot memory with insert, remove
// and sample by random index.
// ----------------------------------------------------------------------------
// channel   signals                 transfer
// command   start, busy, cmd        start && !busy
// result    done, result            done (one cycle, no stall)
//
// Insert and remove scan the occupied slots before they answer; remove
// then moves the tail element into the freed slot. Sample runs the
// random word through the remainder unit and reads the selected slot.
// Rejected, unused and empty-set commands answer in the cycle after the
// transfer. Set size 0..CAPACITY.
// Reset empties the set. Results cannot be stalled.
// ----------------------------------------------------------------------------
module randomized_multiset_engine #(
  parameter int CAPACITY = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  rme_pkg::cmd_t    cmd,
  output logic             done,
  output rme_pkg::result_t result
);
  import rme_pkg::*;
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_TAIL, S_TAILW, S_DIV, S_SREAD, S_SWAIT
  } state_t;

  state_t        state;
  cmd_t          op;
  logic [CW-1:0] count;
  logic [CW-1:0] issue_idx;
  logic          pend;
  logic [AW-1:0] pend_addr;
  logic [CW-1:0] match_cnt;
  logic [AW-1:0] best_slot;
  logic [CW-1:0] best_rank;
  logic [AW-1:0] sel_addr;

  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wvalue;
  logic [CW-1:0] wrank;
  logic [AW-1:0] raddr;
  logic [31:0]   rvalue;
  logic [CW-1:0] rrank;
  logic          mod_go;
  logic          mod_fin;
  logic [CW-1:0] mod_rem;
  logic          hit;
  logic [CW-1:0] last_idx;
  logic [1:0]    start_err;

  assign busy     = (state != S_IDLE);
  assign hit      = pend && (rvalue == op.item_value);
  assign last_idx = count - 1'b1;

  rme_store #(.CAPACITY(CAPACITY), .AW(AW), .CW(CW)) u_store (
    .clk, .we, .waddr, .wvalue, .wrank, .raddr, .rvalue, .rrank
  );

  rme_mod #(.CW(CW)) u_mod (
    .clk, .rst, .go(mod_go), .dividend(op.random_word), .divisor(count),
    .fin(mod_fin), .remainder(mod_rem)
  );

  always_comb begin
    start_err = ERR_NONE;
    if (cmd.opcode == OP_INSERT && count >= CW'(CAPACITY)) begin
      start_err = ERR_FULL;
    end else if (cmd.opcode == OP_SAMPLE && count == '0) begin
      start_err = ERR_EMPTY;
    end
  end

  always_comb begin
    raddr = sel_addr;
    unique case (state)
      S_SCAN:  raddr = issue_idx[AW-1:0];
      S_TAIL:  raddr = last_idx[AW-1:0];
      default: raddr = sel_addr;
    endcase
  end

  always_comb begin
    we     = 1'b0;
    waddr  = count[AW-1:0];
    wvalue = op.item_value;
    wrank  = match_cnt;
    if (state == S_SCAN && issue_idx == count && !pend &&
        op.opcode == OP_INSERT) begin
      we = 1'b1;
    end else if (state == S_TAILW) begin
      we     = 1'b1;
      waddr  = best_slot;
      wvalue = rvalue;
      wrank  = rrank;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      done   <= 1'b0;
      mod_go <= 1'b0;
      pend   <= 1'b0;
    end else begin
      done   <= 1'b0;
      mod_go <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op        <= cmd;
            issue_idx <= '0;
            match_cnt <= '0;
            pend      <= 1'b0;
            result    <= '{op_flag: 1'b0, sampled_value: '0, error_code: start_err,
                           element_total: TOTAL_W'(count)};
            priority if (cmd.opcode == OP_INSERT) begin
              if (count >= CW'(CAPACITY)) begin
                done <= 1'b1;
              end else begin
                state <= S_SCAN;
              end
            end else if (cmd.opcode == OP_REMOVE) begin
              if (count == '0) begin
                done <= 1'b1;
              end else begin
                state <= S_SCAN;
              end
            end else if (cmd.opcode == OP_SAMPLE) begin
              if (count == '0) begin
                done <= 1'b1;
              end else begin
                mod_go <= 1'b1;
                state  <= S_DIV;
              end
            end else begin
              done <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          pend      <= (issue_idx != count);
          pend_addr <= issue_idx[AW-1:0];
          if (issue_idx != count) begin
            issue_idx <= issue_idx + 1'b1;
          end
          if (hit) begin
            match_cnt <= match_cnt + 1'b1;
            if (match_cnt == '0 || rrank > best_rank) begin
              best_slot <= pend_addr;
              best_rank <= rrank;
            end
          end
          if (issue_idx == count && !pend) begin
            if (op.opcode == OP_INSERT) begin
              count  <= count + 1'b1;
              result <= '{op_flag: (match_cnt == '0), sampled_value: '0,
                          error_code: ERR_NONE,
                          element_total: TOTAL_W'(count + 1'b1)};
              done   <= 1'b1;
              state  <= S_IDLE;
            end else if (match_cnt == '0) begin
              done  <= 1'b1;
              state <= S_IDLE;
            end else begin
              state <= S_TAIL;
            end
          end
        end
        S_TAIL: state <= S_TAILW;
        S_TAILW: begin
          count  <= last_idx;
          result <= '{op_flag: 1'b1, sampled_value: '0, error_code: ERR_NONE,
                      element_total: TOTAL_W'(last_idx)};
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        S_DIV: begin
          if (mod_fin) begin
            sel_addr <= mod_rem[AW-1:0];
            state    <= S_SREAD;
          end
        end
        S_SREAD: state <= S_SWAIT;
        S_SWAIT: begin
          result.sampled_value <= rvalue;
          done                 <= 1'b1;
          state                <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### rtl/rme_checker.sv
// ----------------------------------------------------------------------------
// rme_checker
// Port-level checks on the command and result transfers.
// ----------------------------------------------------------------------------
module rme_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input rme_pkg::result_t result
);
  import rme_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("command transfer raised neither busy nor a result");

  a_done_on_release: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> done)
    else $error("busy dropped without a result");

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start)))
    else $error("result without a command");

  a_no_flag_on_error: assert property (@(posedge clk) disable iff (rst)
    (done && result.error_code != ERR_NONE) |-> !result.op_flag)
    else $error("flag set on an error result");

  a_empty_sample: assert property (@(posedge clk) disable iff (rst)
    (done && result.error_code == ERR_EMPTY) |->
      (result.element_total == '0 && result.sampled_value == '0))
    else $error("empty-set error with data");
endmodule

bind randomized_multiset_engine rme_checker u_rme_checker (
  .clk, .rst, .start, .busy, .done, .result
);
